// ===== rtl/glyph_cell_renderer_defines.svh =====
// ----------------------------------------------------------------------------
// glyph_cell_renderer_defines
// Assertion macros used by the checker file of the glyph cell renderer.
// ----------------------------------------------------------------------------
`ifndef GLYPH_CELL_RENDERER_DEFINES_SVH
`define GLYPH_CELL_RENDERER_DEFINES_SVH

// Checked only while the block is out of reset.
`define GCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg
// Types, grid constants and the 5x7 column font of the glyph cell renderer.
// ----------------------------------------------------------------------------
package gcr_pkg;

    typedef logic signed [10:0] pos_t;
    typedef logic signed [11:0] cell_pos_t;
    typedef logic [15:0]        color_t;
    typedef logic [7:0]         code_t;
    typedef logic [3:0]         scale_t;
    typedef logic [2:0]         side_t;
    typedef logic [6:0]         glyph_idx_t;
    typedef logic [2:0]         grid_idx_t;
    typedef logic [7:0]         dot_col_t;

    localparam int GLYPH_COUNT = 95;
    localparam int DOT_COLS    = 5;
    localparam int DOT_ROWS    = 7;
    localparam int GRID_COLS   = 6;
    localparam int GRID_ROWS   = 8;

    localparam code_t FIRST_CODE    = 8'h20;
    localparam code_t LAST_CODE     = 8'h7E;
    localparam code_t FALLBACK_CODE = 8'h3F;

    localparam grid_idx_t LAST_COL = grid_idx_t'(GRID_COLS - 1);
    localparam grid_idx_t LAST_ROW = grid_idx_t'(GRID_ROWS - 1);

    // One entry per printable code; bit r of each column word is dot row r.
    localparam dot_col_t GLYPH_ROM [0:GLYPH_COUNT-1][0:DOT_COLS-1] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h0C,8'h52,8'h52,8'h52,8'h3E},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
        '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
        '{8'h10,8'h08,8'h08,8'h10,8'h08}
    };

endpackage

// ===== rtl/glyph_cell_renderer.sv =====
// ----------------------------------------------------------------------------
// glyph_cell_renderer
// Expands one character into 48 coloured cell squares from a 5x7 column font.
//
//   channel  handshake          words
//   input    start / busy       pos_x pos_y char_code fg_color bg_color
//                               scale_halves
//   output   cell_strobe        cell_x cell_y cell_side cell_color
//                               write_enable last_cell
//
// The cells of a character are issued in turn, set by the result channel that
// carries one cell word per cycle. busy falls during the cycle that issues
// the last cell, so characters follow one another without a gap.
// After start is accepted, the first cell passes the sequencer, the font read
// stage and the output register to the outputs. Reset clears the sequencer and
// cell_strobe. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module glyph_cell_renderer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gcr_pkg::pos_t       pos_x,
    input  gcr_pkg::pos_t       pos_y,
    input  gcr_pkg::code_t      char_code,
    input  gcr_pkg::color_t     fg_color,
    input  gcr_pkg::color_t     bg_color,
    input  gcr_pkg::scale_t     scale_halves,
    output logic                cell_strobe,
    output gcr_pkg::cell_pos_t  cell_x,
    output gcr_pkg::cell_pos_t  cell_y,
    output gcr_pkg::side_t      cell_side,
    output gcr_pkg::color_t     cell_color,
    output logic                write_enable,
    output logic                last_cell
);
    import gcr_pkg::*;

    // Sequencer and captured character.
    logic       active_reg, active_next;
    grid_idx_t  col_reg, col_next;
    grid_idx_t  row_reg, row_next;
    glyph_idx_t idx_reg, idx_next;
    pos_t       px_reg, px_next;
    pos_t       py_reg, py_next;
    color_t     fg_reg, fg_next;
    color_t     bg_reg, bg_next;
    scale_t     s2_reg, s2_next;

    // Font read stage.
    logic       s1_valid_reg;
    logic       s1_last_reg;
    grid_idx_t  s1_col_reg;
    grid_idx_t  s1_row_reg;
    pos_t       s1_px_reg;
    pos_t       s1_py_reg;
    color_t     s1_fg_reg;
    color_t     s1_bg_reg;
    scale_t     s1_s2_reg;
    dot_col_t   rom_word_reg;

    // Output register.
    logic       out_valid_reg;
    logic       out_last_reg;
    cell_pos_t  out_x_reg, out_x_next;
    cell_pos_t  out_y_reg, out_y_next;
    side_t      out_side_reg, out_side_next;
    color_t     out_color_reg, out_color_next;
    logic       out_we_reg, out_we_next;

    logic       accept;
    logic       issue_last;
    logic       in_font;
    logic       dot_set;

    // (2*base + idx*s2)/2 with the halving rounded toward zero.
    function automatic cell_pos_t cell_offset(pos_t base, grid_idx_t idx, scale_t s2);
        logic [6:0]         prod;
        logic signed [12:0] sum;
        logic signed [12:0] adj;
        prod = 7'(idx) * 7'(s2);
        sum  = {base[10], base, 1'b0} + $signed({6'b0, prod});
        adj  = sum + 13'(sum[12] & sum[0]);
        return adj[12:1];
    endfunction

    assign issue_last = active_reg && (col_reg == LAST_COL) && (row_reg == LAST_ROW);
    assign busy       = active_reg && !issue_last;
    assign accept     = start && !busy;
    assign in_font    = (char_code >= FIRST_CODE) && (char_code <= LAST_CODE);

    always_comb
    begin
        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        idx_next    = idx_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        s2_next     = s2_reg;
        if (accept)
        begin
            active_next = 1'b1;
            col_next    = '0;
            row_next    = '0;
            idx_next    = in_font ? glyph_idx_t'(char_code - FIRST_CODE)
                                  : glyph_idx_t'(FALLBACK_CODE - FIRST_CODE);
            px_next     = pos_x;
            py_next     = pos_y;
            fg_next     = fg_color;
            bg_next     = bg_color;
            s2_next     = scale_halves;
        end
        else if (active_reg)
        begin
            if (issue_last)
            begin
                active_next = 1'b0;
            end
            else if (row_reg == LAST_ROW)
            begin
                row_next = '0;
                col_next = col_reg + 3'd1;
            end
            else
            begin
                row_next = row_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= active_reg;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        fg_reg  <= fg_next;
        bg_reg  <= bg_next;
        s2_reg  <= s2_next;
    end

    // Registered font read; the spacing column reads as blank. Each cell
    // carries its own copy of the character so the next one can load early.
    always_ff @(posedge clk)
    begin
        if (col_reg < grid_idx_t'(DOT_COLS))
        begin
            rom_word_reg <= GLYPH_ROM[idx_reg][col_reg];
        end
        else
        begin
            rom_word_reg <= '0;
        end
        s1_last_reg <= issue_last;
        s1_col_reg  <= col_reg;
        s1_row_reg  <= row_reg;
        s1_px_reg   <= px_reg;
        s1_py_reg   <= py_reg;
        s1_fg_reg   <= fg_reg;
        s1_bg_reg   <= bg_reg;
        s1_s2_reg   <= s2_reg;
    end

    assign dot_set = (s1_row_reg != LAST_ROW) && rom_word_reg[s1_row_reg];

    always_comb
    begin
        out_x_next     = cell_offset(s1_px_reg, s1_col_reg, s1_s2_reg);
        out_y_next     = cell_offset(s1_py_reg, s1_row_reg, s1_s2_reg);
        out_side_next  = s1_s2_reg[3:1];
        out_color_next = dot_set ? s1_fg_reg : s1_bg_reg;
        out_we_next    = (out_color_next != s1_bg_reg) || (s1_bg_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        out_last_reg  <= s1_last_reg;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_side_reg  <= out_side_next;
        out_color_reg <= out_color_next;
        out_we_reg    <= out_we_next;
    end

    assign cell_strobe  = out_valid_reg;
    assign last_cell    = out_last_reg;
    assign cell_x       = out_x_reg;
    assign cell_y       = out_y_reg;
    assign cell_side    = out_side_reg;
    assign cell_color   = out_color_reg;
    assign write_enable = out_we_reg;

endmodule

// ===== rtl/gcr_checker.sv =====
// ----------------------------------------------------------------------------
// gcr_checker
// Port-level checks of the glyph cell renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "glyph_cell_renderer_defines.svh"

module gcr_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           cell_strobe,
    input  gcr_pkg::side_t cell_side,
    input  logic           last_cell
);
    import gcr_pkg::*;

    // A word accepted always starts a character run.
    `GCR_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted word did not raise busy")

    // The cells of one character come out in consecutive cycles.
    `GCR_ASSERT(a_cells_contiguous, (cell_strobe && !last_cell) |=> cell_strobe,
        "gap inside a character's cell run")

    // The side is fixed for the whole character.
    `GCR_ASSERT(a_side_steady, (cell_strobe && !last_cell) |=> $stable(cell_side),
        "cell side changed within a character")

    // Once reset has been seen at an edge, the block is quiet at the next one.
    `GCR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!busy && !cell_strobe),
        "activity while in reset")

endmodule

bind glyph_cell_renderer gcr_checker u_gcr_checker (.*);
